### src/drps_pkg.sv
// shared types and constants for the dual rangefinder poll sequencer
// no dependencies; imported by the interfaces, the blend unit and the top level
package drps_pkg;

	localparam int WORD_W  = 16;  // width of a raw reading and of a reported distance
	localparam int DIST_W  = 16;  // stored distance width
	localparam int GATE_W  = 16;
	localparam int LIMIT_W = 8;
	localparam int FAIL_W  = 8;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;

	localparam logic [GATE_W-1:0]  GATE_LOW_RST    = GATE_W'(10);
	localparam logic [GATE_W-1:0]  GATE_HIGH_RST   = GATE_W'(500);
	localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST = LIMIT_W'(30);
	localparam logic [FAIL_W-1:0]  FAIL_MAX        = {FAIL_W{1'b1}};

	// register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_GATE_LOW    = 2'd0,
		REG_GATE_HIGH   = 2'd1,
		REG_RETRY_LIMIT = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

	// poll phase; its code is also the bus operation reported for the tick
	typedef enum logic [1:0] {
		PH_ENABLE  = 2'd0,
		PH_TRIGGER = 2'd1,
		PH_ADDRESS = 2'd2,
		PH_READ    = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		OP_NONE     = 2'd0,
		OP_WR_TRIG  = 2'd1,
		OP_WR_ADDR  = 2'd2,
		OP_RD_WORD  = 2'd3
	} bus_op_t;

	typedef logic [DIST_W-1:0] dist_t;

	// gate thresholds handed to the blend unit
	typedef struct packed {
		logic [GATE_W-1:0] low;
		logic [GATE_W-1:0] high;
	} gate_cfg_t;

endpackage

### src/drps_if.sv
// valid/ready channels for sampling ticks and per-tick results
// depends on drps_pkg
interface drps_tick_if import drps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              write_acked;
	logic              read_complete;
	logic [WORD_W-1:0] read_word;

	modport source(output valid, write_acked, read_complete, read_word, input ready);
	modport sink(input valid, write_acked, read_complete, read_word, output ready);
endinterface

interface drps_result_if import drps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        enable_mask;
	logic [1:0]        bus_op;
	logic              active_sensor;
	logic [WORD_W-1:0] distance_first;
	logic [WORD_W-1:0] distance_second;
	logic              updated;
	logic              timed_out;

	modport source(output valid, enable_mask, bus_op, active_sensor, distance_first,
		distance_second, updated, timed_out, input ready);
	modport sink(input valid, enable_mask, bus_op, active_sensor, distance_first,
		distance_second, updated, timed_out, output ready);
endinterface

### src/drps_blend.sv
// range gate and distance filter: new = floor((old + 4*reading)/5)
// depends on drps_pkg; purely combinational, one multiply by the reciprocal of 5
module drps_blend import drps_pkg::*; (
	input  dist_t             old_dist,
	input  logic [WORD_W-1:0] reading,
	input  gate_cfg_t         gate,
	output logic              pass,
	output dist_t             new_dist
);

	localparam int SUM_W  = ((DIST_W > WORD_W) ? DIST_W : WORD_W) + 3;
	localparam int SHIFT  = SUM_W + 2;
	localparam int PROD_W = SUM_W + SHIFT;
	// ceil(2^SHIFT / 5); exact floor for every sum below 2^SUM_W
	localparam logic [SHIFT-1:0] RECIP = SHIFT'(((64'd1 << SHIFT) + 64'd4) / 64'd5);

	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] prod;

	assign pass = (reading > gate.low) && (reading < gate.high);
	assign sum  = SUM_W'(old_dist) + (SUM_W'(reading) << 2);
	assign prod = PROD_W'(sum) * PROD_W'(RECIP);
	assign new_dist = DIST_W'(prod >> SHIFT);

endmodule

### src/dual_rangefinder_poll_sequencer.sv
// dual rangefinder poll sequencer: one result per sampling tick
// path: the accepted tick is held in the input register, then its result in the result register;
// one tick per cycle sustained while results are taken, as the phase/blend update between them is combinational
// ready drops only when both registers hold work and the result is not taken
// arst_n clears phase, sensor, fail count, enables, distances, and restores gate 10/500, limit 30
// depends on drps_pkg, drps_if and drps_blend
module dual_rangefinder_poll_sequencer import drps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	drps_tick_if.sink           tick,
	drps_result_if.source       result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	// configuration
	gate_cfg_t           gate_q;
	logic [LIMIT_W-1:0]  retry_limit_q;
	reg_idx_t            reg_sel;
	logic                cfg_wr;

	// input register
	logic                valid_s1;
	logic                acked_s1;
	logic                complete_s1;
	logic [WORD_W-1:0]   word_s1;

	// sequencer state
	phase_t              phase_q, phase_d;
	logic                sensor_q, sensor_d;
	logic [FAIL_W-1:0]   fail_q, fail_d;
	logic [1:0]          enables_q, enables_d;
	dist_t               dist_q [2];
	dist_t               dist_d [2];
	logic                upd_d, tmo_d;

	// result register
	logic                valid_s2;
	logic                advance;

	logic                blend_pass;
	dist_t               blend_dist;
	logic [FAIL_W-1:0]   fail_inc;
	logic                read_ok;

	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q.low    <= GATE_LOW_RST;
			gate_q.high   <= GATE_HIGH_RST;
			retry_limit_q <= RETRY_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_GATE_LOW:    gate_q.low    <= pwdata[GATE_W-1:0];
				REG_GATE_HIGH:   gate_q.high   <= pwdata[GATE_W-1:0];
				REG_RETRY_LIMIT: retry_limit_q <= pwdata[LIMIT_W-1:0];
				REG_NONE:        ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_GATE_LOW:    prdata = DATA_W'(gate_q.low);
			REG_GATE_HIGH:   prdata = DATA_W'(gate_q.high);
			REG_RETRY_LIMIT: prdata = DATA_W'(retry_limit_q);
			REG_NONE:        prdata = '0;
		endcase
	end

	// handshake: the stage-1 tick moves into the result register when it has room
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			acked_s1    <= tick.write_acked;
			complete_s1 <= tick.read_complete;
			word_s1     <= tick.read_word;
		end
	end

	drps_blend u_blend (
		.old_dist (dist_q[sensor_q]),
		.reading  (word_s1),
		.gate     (gate_q),
		.pass     (blend_pass),
		.new_dist (blend_dist)
	);

	assign fail_inc = (fail_q == FAIL_MAX) ? fail_q : fail_q + FAIL_W'(1);
	assign read_ok  = complete_s1 && blend_pass;

	// next state
	always_comb begin
		phase_d  = phase_q;
		sensor_d = sensor_q;
		fail_d   = fail_q;
		tmo_d    = 1'b0;
		unique case (phase_q)
			PH_ENABLE: begin
				phase_d = PH_TRIGGER;
				fail_d  = '0;
			end
			PH_TRIGGER: begin
				if (acked_s1) phase_d = PH_ADDRESS;
				else          fail_d  = fail_inc;
			end
			PH_ADDRESS: begin
				if (acked_s1) phase_d = PH_READ;
				else          fail_d  = fail_inc;
			end
			PH_READ: begin
				if (complete_s1) begin
					phase_d  = PH_ENABLE;
					sensor_d = !sensor_q;
				end else begin
					fail_d = fail_inc;
				end
			end
		endcase
		// timeout check follows every phase, so the sensor may flip twice
		if (fail_d > FAIL_W'(retry_limit_q)) begin
			phase_d  = PH_ENABLE;
			sensor_d = !sensor_d;
			tmo_d    = 1'b1;
		end
	end

	// enables and distances
	always_comb begin
		enables_d = enables_q;
		dist_d[0] = dist_q[0];
		dist_d[1] = dist_q[1];
		upd_d     = 1'b0;
		unique case (phase_q)
			PH_ENABLE: enables_d = sensor_q ? 2'b10 : 2'b01;
			PH_READ: begin
				if (read_ok) begin
					dist_d[sensor_q] = blend_dist;
					upd_d            = 1'b1;
				end
			end
			PH_TRIGGER, PH_ADDRESS: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_ENABLE;
			sensor_q  <= 1'b0;
			fail_q    <= '0;
			enables_q <= '0;
			dist_q[0] <= '0;
			dist_q[1] <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			sensor_q  <= sensor_d;
			fail_q    <= fail_d;
			enables_q <= enables_d;
			dist_q[0] <= dist_d[0];
			dist_q[1] <= dist_d[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.enable_mask     <= enables_d;
			result.bus_op          <= bus_op_t'(phase_q);
			result.active_sensor   <= sensor_d;
			result.distance_first  <= WORD_W'(dist_d[0]);
			result.distance_second <= WORD_W'(dist_d[1]);
			result.updated         <= upd_d;
			result.timed_out       <= tmo_d;
		end
	end

	assign result.valid = valid_s2;

endmodule

### sim/dual_rangefinder_poll_sequencer_tb.sv
// self-checking testbench for the dual rangefinder poll sequencer: a directed table, then
// random phases over several gate/limit settings, checked against the table or a behavioral predictor
// depends on drps_pkg, drps_if and the sequencer RTL
module dual_rangefinder_poll_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import drps_pkg::*;

	localparam int LIMIT_CYCLES    = 200000;
	localparam int PRESSURE_AT     = 700;
	localparam int PRESSURE_CYCLES = 150;
	localparam int DRAIN_CYCLES    = 8;

	typedef struct packed {
		logic [1:0] enable_mask;
		bus_op_t    bus_op;
		logic       active_sensor;
		dist_t      dist_first;
		dist_t      dist_second;
		logic       updated;
		logic       timed_out;
	} poll_result_t;

	typedef enum logic {ROW_TICK, ROW_LIMIT} row_kind_t;

	// a limit row carries the new retry limit in word
	typedef struct packed {
		row_kind_t    kind;
		logic         acked;
		logic         complete;
		logic [15:0]  word;
		logic         typed;
		poll_result_t want;
	} dir_row_t;

	typedef enum logic [1:0] {STYLE_CLEAN, STYLE_NOISY, STYLE_DEAD} stim_style_t;

	typedef struct packed {
		logic [15:0] gate_lo;
		logic [15:0] gate_hi;
		logic [7:0]  limit;
		int          count;
		stim_style_t style;
		logic        calm;
	} stim_phase_t;

	localparam poll_result_t NO_RESULT = '0;
	localparam int DIR_ROWS = 27;

	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{ROW_TICK, 1'b0, 1'b0, 16'h0000, 1'b1, '{2'b01, OP_NONE, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_TICK, 1'b0, 1'b1, 16'hFFFF, 1'b1, '{2'b01, OP_WR_TRIG, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_TICK, 1'b1, 1'b0, 16'h0000, 1'b1, '{2'b01, OP_WR_TRIG, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_TICK, 1'b0, 1'b0, 16'h0000, 1'b1, '{2'b01, OP_WR_ADDR, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_TICK, 1'b1, 1'b1, 16'hFFFF, 1'b1, '{2'b01, OP_WR_ADDR, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_TICK, 1'b1, 1'b0, 16'hFFFF, 1'b1, '{2'b01, OP_RD_WORD, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0}},
		// lower the limit under the running count
		'{ROW_LIMIT, 1'b0, 1'b0, 16'd1, 1'b0, NO_RESULT},
		// rejected read and timeout on the same tick: sensor toggles twice
		'{ROW_TICK, 1'b0, 1'b1, 16'hFFFF, 1'b1, '{2'b01, OP_RD_WORD, 1'b0, 16'd0, 16'd0, 1'b0, 1'b1}},
		'{ROW_TICK, 1'b1, 1'b1, 16'hFFFF, 1'b1, '{2'b01, OP_NONE, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_TICK, 1'b1, 1'b0, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_TICK, 1'b1, 1'b0, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_TICK, 1'b0, 1'b1, 16'h0000, 1'b1, '{2'b01, OP_RD_WORD, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_TICK, 1'b0, 1'b0, 16'h0000, 1'b1, '{2'b10, OP_NONE, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_TICK, 1'b1, 1'b0, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_TICK, 1'b1, 1'b0, 16'h0000, 1'b0, NO_RESULT},
		// reading equal to the low gate is rejected
		'{ROW_TICK, 1'b0, 1'b1, 16'd10, 1'b1, '{2'b10, OP_RD_WORD, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_TICK, 1'b0, 1'b0, 16'h0000, 1'b1, '{2'b01, OP_NONE, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_TICK, 1'b0, 1'b0, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_TICK, 1'b0, 1'b0, 16'h0000, 1'b1, '{2'b01, OP_WR_TRIG, 1'b1, 16'd0, 16'd0, 1'b0, 1'b1}},
		'{ROW_TICK, 1'b0, 1'b0, 16'h0000, 1'b1, '{2'b10, OP_NONE, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_TICK, 1'b1, 1'b0, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_TICK, 1'b1, 1'b0, 16'h0000, 1'b0, NO_RESULT},
		// reading equal to the high gate is rejected
		'{ROW_TICK, 1'b0, 1'b1, 16'd500, 1'b0, NO_RESULT},
		'{ROW_TICK, 1'b0, 1'b0, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_TICK, 1'b1, 1'b0, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_TICK, 1'b1, 1'b0, 16'h0000, 1'b0, NO_RESULT},
		'{ROW_TICK, 1'b0, 1'b1, 16'd499, 1'b1, '{2'b01, OP_RD_WORD, 1'b1, 16'd399, 16'd0, 1'b1, 1'b0}}
	};

	// noisy phases get their gates and limit drawn at run time
	localparam stim_phase_t PHASES [6] = '{
		'{16'd10, 16'd500, 8'd30, 300, STYLE_CLEAN, 1'b0},
		'{16'd0, 16'hFFFF, 8'd0, 200, STYLE_CLEAN, 1'b1},
		'{16'hFFFF, 16'd0, 8'd255, 300, STYLE_DEAD, 1'b0},
		'{16'd1000, 16'd1200, 8'd3, 200, STYLE_CLEAN, 1'b0},
		'{16'd0, 16'd0, 8'd0, 250, STYLE_NOISY, 1'b0},
		'{16'd100, 16'd60000, 8'd12, 250, STYLE_CLEAN, 1'b0}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	drps_tick_if tick_ch();
	drps_result_if res_ch();

	dual_rangefinder_poll_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_ch),
		.result(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// predictor copy of the registers and sequencer state
	logic [GATE_W-1:0]  cfg_gate_low;
	logic [GATE_W-1:0]  cfg_gate_high;
	logic [LIMIT_W-1:0] cfg_retry;
	phase_t             st_phase;
	logic               st_sensor;
	logic [FAIL_W-1:0]  st_fails;
	dist_t              st_dist [2];
	logic [1:0]         st_enables;

	poll_result_t expected_results [$];
	logic calm;
	int mismatch_count;
	int ticks_sent;
	int results_checked;
	int updates_seen;
	int timeouts_seen;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		do begin
			@(posedge clk);
			cycle_count++;
		end while (cycle_count < LIMIT_CYCLES);
		$display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
		$display("dual_rangefinder_poll_sequencer_tb NOT OK");
		$finish;
	end

	function automatic poll_result_t poll_step(logic acked, logic complete, logic [15:0] word);
		poll_result_t r;
		logic missed;
		int unsigned blend;
		r = '0;
		missed = 1'b0;
		r.bus_op = bus_op_t'(st_phase);
		case (st_phase)
		PH_ENABLE: begin
			st_enables = 2'b01 << st_sensor;
			st_phase = PH_TRIGGER;
			st_fails = '0;
		end
		PH_TRIGGER: begin
			if (acked) st_phase = PH_ADDRESS;
			else missed = 1'b1;
		end
		PH_ADDRESS: begin
			if (acked) st_phase = PH_READ;
			else missed = 1'b1;
		end
		default: begin
			if (complete) begin
				if (word > cfg_gate_low && word < cfg_gate_high) begin
					blend = (32'(st_dist[st_sensor]) + 4 * 32'(word)) / 5;
					st_dist[st_sensor] = dist_t'(blend);
					r.updated = 1'b1;
				end
				st_sensor = ~st_sensor;
				st_phase = PH_ENABLE;
			end else begin
				missed = 1'b1;
			end
		end
		endcase
		// failure count sticks at its top value
		if (missed && st_fails != FAIL_MAX) st_fails = st_fails + 1'b1;
		if (st_fails > cfg_retry) begin
			st_phase = PH_ENABLE;
			st_sensor = ~st_sensor;
			r.timed_out = 1'b1;
		end
		r.enable_mask = st_enables;
		r.active_sensor = st_sensor;
		r.dist_first = st_dist[0];
		r.dist_second = st_dist[1];
		return r;
	endfunction

	function automatic logic [15:0] pick_word();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 6 && 32'(cfg_gate_high) > 32'(cfg_gate_low) + 1)
			return 16'($urandom_range(32'(cfg_gate_low) + 1, 32'(cfg_gate_high) - 1));
		case (sel)
		6: return cfg_gate_low;
		7: return cfg_gate_high;
		8: return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
		default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_tick(logic acked, logic complete, logic [15:0] word, logic typed,
			poll_result_t want);
		int gap;
		poll_result_t predicted;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.write_acked <= acked;
		tick_ch.read_complete <= complete;
		tick_ch.read_word <= word;
		do @(posedge clk); while (tick_ch.ready !== 1'b1);
		predicted = poll_step(acked, complete, word);
		expected_results.push_back(typed ? want : predicted);
		ticks_sent++;
	endtask

	// registers change only with the pipeline empty
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		tick_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
		REG_GATE_LOW:    cfg_gate_low = value[GATE_W-1:0];
		REG_GATE_HIGH:   cfg_gate_high = value[GATE_W-1:0];
		REG_RETRY_LIMIT: cfg_retry = value[LIMIT_W-1:0];
		default: ;
		endcase
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// result side: random stalls, one long hold-off to back the block up
	initial begin
		int stall;
		poll_result_t want;
		res_ch.ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (results_checked == PRESSURE_AT) stall = PRESSURE_CYCLES;
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with no request outstanding", $time);
			end else begin
				want = expected_results.pop_front();
				check_field("enable_mask", 16'(want.enable_mask), 16'(res_ch.enable_mask));
				check_field("bus_op", 16'(want.bus_op), 16'(res_ch.bus_op));
				check_field("active_sensor", 16'(want.active_sensor), 16'(res_ch.active_sensor));
				check_field("distance_first", want.dist_first, res_ch.distance_first);
				check_field("distance_second", want.dist_second, res_ch.distance_second);
				check_field("updated", 16'(want.updated), 16'(res_ch.updated));
				check_field("timed_out", 16'(want.timed_out), 16'(res_ch.timed_out));
			end
			results_checked++;
			if (res_ch.updated === 1'b1) updates_seen++;
			if (res_ch.timed_out === 1'b1) timeouts_seen++;
		end
	end

	initial begin
		dir_row_t row;
		stim_phase_t ph;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [7:0] lim;
		logic acked;
		logic complete;
		logic [15:0] word;
		mismatch_count = 0;
		ticks_sent = 0;
		results_checked = 0;
		updates_seen = 0;
		timeouts_seen = 0;
		calm = 1'b0;
		cfg_gate_low = GATE_LOW_RST;
		cfg_gate_high = GATE_HIGH_RST;
		cfg_retry = RETRY_LIMIT_RST;
		st_phase = PH_ENABLE;
		st_sensor = 1'b0;
		st_fails = '0;
		st_dist[0] = '0;
		st_dist[1] = '0;
		st_enables = '0;
		arst_n <= 1'b0;
		tick_ch.valid <= 1'b0;
		tick_ch.write_acked <= 1'b0;
		tick_ch.read_complete <= 1'b0;
		tick_ch.read_word <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_LIMIT)
				write_reg(REG_RETRY_LIMIT, 32'(row.word));
			else
				send_tick(row.acked, row.complete, row.word, row.typed, row.want);
		end

		foreach (PHASES[p]) begin
			ph = PHASES[p];
			lo = ph.gate_lo;
			hi = ph.gate_hi;
			lim = ph.limit;
			if (ph.style == STYLE_NOISY) begin
				lo = 16'($urandom);
				hi = 16'($urandom);
				lim = 8'($urandom_range(0, 255));
			end
			write_reg(REG_GATE_LOW, 32'(lo));
			write_reg(REG_GATE_HIGH, 32'(hi));
			write_reg(REG_RETRY_LIMIT, 32'(lim));
			calm = ph.calm;
			for (int n = 0; n < ph.count; n++) begin
				case (ph.style)
				STYLE_CLEAN: begin
					acked = ($urandom_range(0, 7) != 0);
					complete = ($urandom_range(0, 7) != 0);
					word = pick_word();
				end
				STYLE_DEAD: begin
					// sensor acks writes but never answers the read
					acked = 1'b1;
					complete = 1'b0;
					word = 16'($urandom);
				end
				default: begin
					acked = 1'($urandom);
					complete = 1'($urandom);
					word = 16'($urandom);
				end
				endcase
				send_tick(acked, complete, word, 1'b0, NO_RESULT);
			end
		end

		tick_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d ticks over %0d register settings, %0d results checked",
			ticks_sent, $size(PHASES) + 2, results_checked);
		$display("distance updates %0d, retry timeouts %0d, mismatches %0d",
			updates_seen, timeouts_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("dual_rangefinder_poll_sequencer_tb OK");
		else
			$display("dual_rangefinder_poll_sequencer_tb NOT OK");
		$finish;
	end

endmodule

### filelist.f
src/drps_pkg.sv
src/drps_if.sv
src/drps_blend.sv
src/dual_rangefinder_poll_sequencer.sv
sim/dual_rangefinder_poll_sequencer_tb.sv
